>>> hdl/capture_period_frequency_meter_top_defines.svh
// ----------------------------------------------------------------------------
// Capture period frequency meter: assertion macros
// Shared assertion helpers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_PERIOD_FREQUENCY_METER_TOP_DEFINES_SVH
`define CAPTURE_PERIOD_FREQUENCY_METER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CPFM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpfm assertion failed");

// next-cycle implication
`define CPFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpfm assertion failed");

`else

`define CPFM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CPFM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/cpfm_pkg.sv
// ----------------------------------------------------------------------------
// cpfm_pkg
// Constants and shared types of the capture period frequency meter.
// ----------------------------------------------------------------------------
package cpfm_pkg;

    localparam int WINDOW_DELTAS = 16;              // periods per window
    localparam int TIME_W        = 32;              // capture counter width
    localparam int SUM_W         = 42;              // period sum width
    localparam int CNT_W         = $clog2(WINDOW_DELTAS + 2);
    localparam int NUM_W         = TIME_W + $clog2(WINDOW_DELTAS + 1);
    localparam int BIT_W         = $clog2(SUM_W);
    localparam int DIV_CNT_W     = $clog2(NUM_W + 1);

    localparam logic [TIME_W-1:0] CLOCK_HZ_RESET = 32'd16000000;

    // commands into the serial accumulator
    typedef struct packed {
        logic clear;
        logic first;
        logic start;
    } acc_cmd_t;

    // status of a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

>>> hdl/cpfm_serial_acc.sv
// ----------------------------------------------------------------------------
// cpfm_serial_acc
// Bit-serial period former: difference, running sum, min and max, LSB first.
// ----------------------------------------------------------------------------
module cpfm_serial_acc
    import cpfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  acc_cmd_t          cmd,
    input  logic [TIME_W-1:0] capture_time,
    output unit_stat_t        stat,
    output logic [SUM_W-1:0]  sum,
    output logic [TIME_W-1:0] min_period,
    output logic [TIME_W-1:0] max_period
);

    logic              busy_reg;
    logic              done_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] prev_reg;
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] min_reg;
    logic [TIME_W-1:0] max_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              borrow_reg;
    logic              carry_reg;
    logic              lt_reg;
    logic              gt_reg;

    logic lo, last;
    logic pbit, abit, sbit;
    logic borrow_next, carry_next, lt_next, gt_next;

    always_comb
    begin
        lo          = (bit_reg < BIT_W'(TIME_W));
        last        = (bit_reg == BIT_W'(SUM_W - 1));
        // period bit: t - prev
        pbit        = t_reg[0] ^ prev_reg[0] ^ borrow_reg;
        borrow_next = (~t_reg[0] & prev_reg[0]) |
                      (~(t_reg[0] ^ prev_reg[0]) & borrow_reg);
        // sum bit: period is zero above bit 31
        abit        = lo & pbit;
        sbit        = sum_reg[0] ^ abit ^ carry_reg;
        carry_next  = (sum_reg[0] & abit) | (carry_reg & (sum_reg[0] ^ abit));
        // LSB-first compares: a higher bit overrides lower decisions
        lt_next     = (~pbit & min_reg[0]) | (~(pbit ^ min_reg[0]) & lt_reg);
        gt_next     = (pbit & ~max_reg[0]) | (~(pbit ^ max_reg[0]) & gt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            bit_reg    <= '0;
            prev_reg   <= '0;
            sum_reg    <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
            borrow_reg <= 1'b0;
            carry_reg  <= 1'b0;
            lt_reg     <= 1'b0;
            gt_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.clear)
            begin
                busy_reg <= 1'b0;
                prev_reg <= '0;
                sum_reg  <= '0;
                min_reg  <= '1;
                max_reg  <= '0;
            end
            else if (cmd.first)
            begin
                prev_reg <= capture_time;
            end
            else if (cmd.start)
            begin
                busy_reg   <= 1'b1;
                bit_reg    <= '0;
                borrow_reg <= 1'b0;
                carry_reg  <= 1'b0;
                lt_reg     <= 1'b0;
                gt_reg     <= 1'b0;
            end
            else if (busy_reg)
            begin
                sum_reg   <= {sbit, sum_reg[SUM_W-1:1]};
                carry_reg <= carry_next;
                bit_reg   <= bit_reg + 1'b1;
                if (lo)
                begin
                    prev_reg   <= {prev_reg[0], prev_reg[TIME_W-1:1]};
                    min_reg    <= {min_reg[0], min_reg[TIME_W-1:1]};
                    max_reg    <= {max_reg[0], max_reg[TIME_W-1:1]};
                    borrow_reg <= borrow_next;
                    lt_reg     <= lt_next;
                    gt_reg     <= gt_next;
                end
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    prev_reg <= t_reg;          // rotated back to original
                    if (lt_reg)
                    begin
                        min_reg <= period_reg;
                    end
                    if (gt_reg)
                    begin
                        max_reg <= period_reg;
                    end
                end
            end
        end
    end

    // payload shift registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            t_reg <= capture_time;
        end
        else if (busy_reg && lo)
        begin
            t_reg      <= {t_reg[0], t_reg[TIME_W-1:1]};
            period_reg <= {pbit, period_reg[TIME_W-1:1]};
        end
    end

    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;
    assign sum        = sum_reg;
    assign min_period = min_reg;
    assign max_period = max_reg;

endmodule

>>> hdl/cpfm_divider.sv
// ----------------------------------------------------------------------------
// cpfm_divider
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// ----------------------------------------------------------------------------
module cpfm_divider
    import cpfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  numer,
    input  logic [SUM_W-1:0]  denom,
    output unit_stat_t        stat,
    output logic [TIME_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [NUM_W-1:0]     q_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [SUM_W-1:0]     den_reg;

    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   diff;
    logic             ge;
    logic [SUM_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = (|q_reg[NUM_W-1:TIME_W]) ? '1 : q_reg[TIME_W-1:0];

endmodule

>>> hdl/capture_period_frequency_meter_top.sv
// ----------------------------------------------------------------------------
// capture_period_frequency_meter_top
// Period statistics and reciprocal frequency from input-capture timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one request carries kind and
//   capture_time. kind 0 is a capture, kind 1 empties the window.
//   The first capture of a window only stores its time. Each later capture
//   adds one period; the capture that completes WINDOW_DELTAS periods
//   produces one result request on the output channel (out_valid/out_ready)
//   with min_period, max_period, frequency_hz and zero_sum, and the window
//   restarts empty.
//   Config channel (cfg_valid/cfg_data, always ready) writes clock_hz;
//   write it only while the block is idle.
// Sequence:
//   Clear and first captures are handled in the idle state. Other captures run
//   bit-serially through the period former over all SUM_W (42) bits of the sum.
//   The closing capture adds a restoring division, one bit a cycle, over NUM_W
//   (37) bits; a zero sum skips the division. New requests are taken only
//   while the block is idle, once the serial accumulator and the divider
//   have finished with the last one.
// Reset: clock_hz returns to 16 MHz and the window is empty.
// Stall: a result waits in the output register; the block keeps taking
//   requests until the next result is ready, then holds until it is taken.
// ----------------------------------------------------------------------------
`include "capture_period_frequency_meter_top_defines.svh"

module capture_period_frequency_meter_top
    import cpfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input requests
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [TIME_W-1:0] capture_time,
    // result requests
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TIME_W-1:0] min_period,
    output logic [TIME_W-1:0] max_period,
    output logic [TIME_W-1:0] frequency_hz,
    output logic              zero_sum,
    // clock_hz register write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TIME_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;       // captures seen in window
    logic              closing_reg, closing_next;
    logic              zero_reg, zero_next;
    logic [TIME_W-1:0] clock_hz_reg;

    logic              out_valid_reg, out_valid_next;
    logic [TIME_W-1:0] min_out_reg;
    logic [TIME_W-1:0] max_out_reg;
    logic [TIME_W-1:0] freq_out_reg;
    logic              zero_out_reg;

    acc_cmd_t          acc_cmd;
    unit_stat_t        acc_stat;
    logic [SUM_W-1:0]  acc_sum;
    logic [TIME_W-1:0] acc_min;
    logic [TIME_W-1:0] acc_max;

    logic              div_start;
    unit_stat_t        div_stat;
    logic [NUM_W-1:0]  div_numer;
    logic [TIME_W-1:0] div_quot;

    logic              in_fire;
    logic              load_out;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign cfg_ready = 1'b1;

    // clock_hz * WINDOW_DELTAS
    assign div_numer = NUM_W'(clock_hz_reg) * NUM_W'(WINDOW_DELTAS);

    cpfm_serial_acc u_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (acc_cmd),
        .capture_time (capture_time),
        .stat         (acc_stat),
        .sum          (acc_sum),
        .min_period   (acc_min),
        .max_period   (acc_max)
    );

    cpfm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (acc_sum),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        closing_next = closing_reg;
        zero_next    = zero_reg;
        acc_cmd      = '0;
        div_start    = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind)
                    begin
                        acc_cmd.clear = 1'b1;
                        cnt_next      = '0;
                    end
                    else if (cnt_reg == '0)
                    begin
                        acc_cmd.first = 1'b1;
                        cnt_next      = CNT_W'(1);
                    end
                    else
                    begin
                        acc_cmd.start = 1'b1;
                        closing_next  = (cnt_reg == CNT_W'(WINDOW_DELTAS));
                        cnt_next      = cnt_reg + 1'b1;
                        state_next    = ST_ACC;
                    end
                end
            end
            ST_ACC:
            begin
                if (acc_stat.done)
                begin
                    if (!closing_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (acc_sum == '0)
                    begin
                        zero_next  = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        zero_next  = 1'b0;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    load_out      = 1'b1;
                    acc_cmd.clear = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            closing_reg   <= 1'b0;
            zero_reg      <= 1'b0;
            clock_hz_reg  <= CLOCK_HZ_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            closing_reg   <= closing_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                clock_hz_reg <= cfg_data;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            min_out_reg  <= acc_min;
            max_out_reg  <= acc_max;
            freq_out_reg <= zero_reg ? '0 : div_quot;
            zero_out_reg <= zero_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign min_period   = min_out_reg;
    assign max_period   = max_out_reg;
    assign frequency_hz = freq_out_reg;
    assign zero_sum     = zero_out_reg;

    // window count never runs past its closing capture while idle
    `CPFM_ASSERT_IMPL(a_cnt_bound, clk, rst_n, state_reg == ST_IDLE, cnt_reg <= CNT_W'(WINDOW_DELTAS))
    // with two or more captures the window holds at least one period
    `CPFM_ASSERT_IMPL(a_min_le_max, clk, rst_n, (state_reg == ST_IDLE) && (cnt_reg >= CNT_W'(2)), acc_min <= acc_max)
    // no unit left running when new requests are taken
    `CPFM_ASSERT_IMPL(a_idle_units, clk, rst_n, state_reg == ST_IDLE, !acc_stat.busy && !div_stat.busy)
    // a delivered window leaves the accumulator empty
    `CPFM_ASSERT_NEXT(a_clear_after_out, clk, rst_n, load_out, (acc_sum == '0) && (cnt_reg == '0))

endmodule

>>> bench/capture_period_frequency_meter_top_tb.sv
// ----------------------------------------------------------------------------
// capture_period_frequency_meter_top_tb
// Self-checking bench: a short table of capture and clear requests, then
// random capture windows under several clock_hz settings. Every result
// request is checked against the expectation of its table row or a local model
// of the period statistics and of the reciprocal frequency.
// ----------------------------------------------------------------------------
module capture_period_frequency_meter_top_tb;
    import cpfm_pkg::*;

    // request kinds on the input channel
    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    // Settling wait, long enough for the block to finish a closing capture
    // with its division as well as any other capture.
    localparam int BLOCK_SETTLE = 128;
    // Watchdog limit, set with a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int IDLE_PCT     = 35;

    typedef struct packed {
        logic [TIME_W-1:0] low_period;
        logic [TIME_W-1:0] high_period;
        logic [TIME_W-1:0] freq_hz;
        logic              no_periods;
    } reading_t;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct {
        logic              kind;
        logic [TIME_W-1:0] stamp;
        bit                typed;
        reading_t          reading;
    } table_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              kind = KIND_CAPTURE;
    logic [TIME_W-1:0] capture_time = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [TIME_W-1:0] min_period;
    logic [TIME_W-1:0] max_period;
    logic [TIME_W-1:0] frequency_hz;
    logic              zero_sum;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [TIME_W-1:0] cfg_data = '0;

    // model of the block: register copy and window accumulators
    logic [TIME_W-1:0] clk_hz_copy;
    logic [TIME_W-1:0] last_stamp;
    int unsigned       stamps_in_window;
    logic [SUM_W-1:0]  tick_sum;
    logic [TIME_W-1:0] tick_min;
    logic [TIME_W-1:0] tick_max;

    reading_t          pending_readings[$];
    int unsigned       fail_count = 0;
    int unsigned       cycle_count = 0;
    bit                steady_run = 1'b0;   // no idling on either side
    table_row_t        capture_table[23];

    capture_period_frequency_meter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .capture_time (capture_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .min_period   (min_period),
        .max_period   (max_period),
        .frequency_hz (frequency_hz),
        .zero_sum     (zero_sum),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Window model
    // ------------------------------------------------------------------
    function automatic void empty_window();
        last_stamp       = '0;
        stamps_in_window = 0;
        tick_sum         = '0;
        tick_min         = '1;
        tick_max         = '0;
    endfunction

    // Advances the model by one accepted request; returns 1 when the
    // request closes a window, with the reading the block must give.
    function automatic bit window_reading(input logic k, input logic [TIME_W-1:0] t,
                                          output reading_t r);
        logic [TIME_W-1:0] period;
        logic [63:0]       numer;
        logic [63:0]       quot;
        r = '0;
        if (k == KIND_CLEAR)
        begin
            empty_window();
            return 1'b0;
        end
        // first capture of a window only marks the start
        if (stamps_in_window == 0)
        begin
            last_stamp       = t;
            stamps_in_window = 1;
            return 1'b0;
        end
        period     = t - last_stamp;            // modulo 2^32, survives a wrap
        last_stamp = t;
        tick_sum   = tick_sum + SUM_W'(period);
        if (period < tick_min)
            tick_min = period;
        if (period > tick_max)
            tick_max = period;
        stamps_in_window++;
        if (stamps_in_window < WINDOW_DELTAS + 1)
            return 1'b0;

        r.low_period  = tick_min;
        r.high_period = tick_max;
        if (tick_sum == '0)
        begin
            r.no_periods = 1'b1;
            r.freq_hz    = '0;
        end
        else
        begin
            numer = 64'(clk_hz_copy) * 64'(WINDOW_DELTAS);
            quot  = numer / 64'(tick_sum);
            // quotients past 32 bits saturate
            r.freq_hz = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[TIME_W-1:0];
        end
        // the closing capture does not open the next window
        empty_window();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Called at a rising edge. Valid is lowered only when a gap is taken,
    // so back-to-back requests never see a low/high pair in one step.
    task automatic send_request(input logic k, input logic [TIME_W-1:0] t,
                                input bit typed, input reading_t typed_reading);
        reading_t r;
        bit       closes;
        if (!steady_run && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (!steady_run && $urandom_range(0, 99) < IDLE_PCT);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        capture_time <= t;
        // handshake is judged at the falling edge, taken at the next rise
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        closes = window_reading(k, t, r);
        if (typed)
            pending_readings.push_back(typed_reading);
        else if (closes)
            pending_readings.push_back(r);
    endtask

    // Sender goes quiet until every result is back and the block has
    // had time to finish any request that gives none.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (BLOCK_SETTLE) @(posedge clk);
    endtask

    task automatic write_clock_hz(input logic [TIME_W-1:0] hz);
        cfg_valid <= 1'b1;
        cfg_data  <= hz;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid   <= 1'b0;
        clk_hz_copy  = hz;
    endtask

    // Random windows: mostly 17 well-formed captures with a period style
    // picked per window, sprinkled with clears that break windows.
    task automatic feed_windows(input int budget);
        int                sent;
        int                style;
        int                n;
        logic [TIME_W-1:0] t;
        sent = 0;
        while (sent < budget)
        begin
            style = $urandom_range(0, 9);
            t     = (style == 7) ? 32'hFFFF_FFFF - $urandom_range(0, 20000) : $urandom;
            if ($urandom_range(0, 99) < 4)
            begin
                send_request(KIND_CLEAR, $urandom, 1'b0, '0);
                sent++;
            end
            for (n = 0; n < WINDOW_DELTAS + 1; n++)
            begin
                if ($urandom_range(0, 99) < 3)
                begin
                    send_request(KIND_CLEAR, $urandom, 1'b0, '0);
                    sent++;
                end
                send_request(KIND_CAPTURE, t, 1'b0, '0);
                sent++;
                case (style)
                    4: t = $urandom;                              // any period
                    5: ;                                          // frozen: zero sum
                    6: t = t + $urandom_range(0, 2);              // tiny: can saturate
                    8: t = t + ($urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                                     : 32'($urandom_range(0, 3)));
                    9:
                    begin
                        case ($urandom_range(0, 3))
                            0: ;
                            1: t = t + 1;
                            2: t = t + $urandom;
                            default: t = t - 1;                   // period of all ones
                        endcase
                    end
                    default: t = t + $urandom_range(1, 5000);     // ordinary, wraps too
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, compare every accepted result
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    initial
    begin
        reading_t want;
        forever
        begin
            @(posedge clk);
            out_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_readings.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected result: expected none, actual %h %h %h %b",
                             $time, min_period, max_period, frequency_hz, zero_sum);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    check_field("min_period", want.low_period, min_period);
                    check_field("max_period", want.high_period, max_period);
                    check_field("frequency_hz", want.freq_hz, frequency_hz);
                    check_field("zero_sum", TIME_W'(want.no_periods), TIME_W'(zero_sum));
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int                row;
        int                phase;
        logic [TIME_W-1:0] hz;

        // Directed table, run with clock_hz at its top value so that the
        // one-tick window below saturates the frequency.
        capture_table = '{
            '{KIND_CLEAR,   32'hFFFF_FFFF, 1'b0, '0},   // clear on an empty window
            '{KIND_CAPTURE, 32'h1234_5678, 1'b0, '0},   // first capture, start mark
            '{KIND_CAPTURE, 32'h1234_5680, 1'b0, '0},   // one period of 8
            '{KIND_CLEAR,   32'h0000_0000, 1'b0, '0},   // clear mid-window
            '{KIND_CAPTURE, 32'hFFFF_FFFF, 1'b0, '0},   // new window starts at top
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},   // counter wrap: period 1
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},   // zero periods from here on
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            '{KIND_CAPTURE, 32'h0000_0000, 1'b0, '0},
            // sixteenth period closes: sum 1, frequency saturates
            '{KIND_CAPTURE, 32'h0000_0000, 1'b1,
              '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0}},
            '{KIND_CAPTURE, 32'h0000_0005, 1'b0, '0},   // restart: a fresh first capture
            '{KIND_CLEAR,   32'hFFFF_FFFF, 1'b0, '0}
        };

        clk_hz_copy = CLOCK_HZ_RESET;
        empty_window();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        write_clock_hz(32'hFFFF_FFFF);
        for (row = 0; row < 23; row++)
            send_request(capture_table[row].kind, capture_table[row].stamp,
                         capture_table[row].typed, capture_table[row].reading);

        // Random phases, each under its own clock_hz; the register is only
        // written once the block has gone idle.
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: hz = CLOCK_HZ_RESET;
                1: hz = 32'h0000_0001;
                2: hz = 32'hFFFF_FFFF;
                3: hz = $urandom_range(1, 100000000);
                default: hz = $urandom | 32'h1;
            endcase
            settle_block();
            write_clock_hz(hz);
            steady_run = (phase == 2);
            if (phase == 3)
            begin
                // a mid-phase pause that lets the output queue run dry
                feed_windows(200);
                settle_block();
                feed_windows(200);
            end
            else
                feed_windows(400);
        end
        steady_run = 1'b0;
        settle_block();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> capture_period_frequency_meter_top.f
+incdir+hdl
hdl/cpfm_pkg.sv
hdl/cpfm_serial_acc.sv
hdl/cpfm_divider.sv
hdl/capture_period_frequency_meter_top.sv
bench/capture_period_frequency_meter_top_tb.sv
